/* design/sne_pkg.sv */
// Shared types, codes and arithmetic helpers for the Sobel edge thinning block.
// Used by sne_ctrl, sne_datapath and sobel_nms_edge_thinning; depends on nothing.
package sne_pkg;

   // field and register widths
   localparam int PIXEL_W      = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;
   localparam int CSR_DATA_W   = 12;
   localparam int CSR_INDEX_W  = 1;
   localparam int STRENGTH_W   = 11;
   localparam int DIR_W        = 2;
   localparam int GRAD_W       = 11;
   localparam int SQUARE_W     = 20;
   localparam int MAG_W        = 21;

   // frame limits
   localparam int MIN_SIZE   = 3;
   localparam int MAX_HEIGHT = 4095;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // sequencing constants
   localparam int WIN        = 5;
   localparam int FETCH_LAT  = 4;
   localparam int ROOT_STEPS = 11;
   localparam logic [MAG_W-1:0] ROOT_FIRST_BIT = MAG_W'(1) << (MAG_W - 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // item operations
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // comparison axes
   localparam logic [DIR_W-1:0] DIR_VERTICAL   = 2'd0;
   localparam logic [DIR_W-1:0] DIR_ANTI_DIAG  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_HORIZONTAL = 2'd2;
   localparam logic [DIR_W-1:0] DIR_DIAGONAL   = 2'd3;

   // which gradient the shared unit works on
   localparam logic [1:0] SEL_CENTER = 2'd0;
   localparam logic [1:0] SEL_FIRST  = 2'd1;
   localparam logic [1:0] SEL_SECOND = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_FLUSH,
      ST_GRAD,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       push;
      logic       fetch_issue;
      logic [2:0] fetch_row;
      logic [2:0] fetch_col;
      logic       grad_load;
      logic [1:0] grad_sel;
      logic       square;
      logic       sum;
      logic       root_init;
      logic       root_step;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      logic emit_ready;
      logic out_busy;
   } dp_status_type;

   typedef logic [8:0][PIXEL_W-1:0] patch_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] dx;
      logic signed [GRAD_W-1:0] dy;
   } grad_type;

   // 3x3 Sobel on a patch stored row by row
   function automatic grad_type sobel(input patch_type p);
      logic signed [GRAD_W-1:0] q [9];
      grad_type g;
      for (int k = 0; k < 9; k++) begin
         q[k] = $signed(GRAD_W'(p[k]));
      end
      g.dx = (q[2] - q[0]) + ((q[5] - q[3]) <<< 1) + (q[8] - q[6]);
      g.dy = (q[6] - q[0]) + ((q[7] - q[1]) <<< 1) + (q[8] - q[2]);
      return g;
   endfunction

endpackage

/* design/sne_ctrl.sv */
// Sequencer for the Sobel edge thinning block: takes items and steps the datapath.
// Depends on sne_pkg for the state type and the command and status structs.
module sne_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_operation,
   output logic                  req_stall,
   output sne_pkg::dp_cmd_type   cmd,
   input  sne_pkg::dp_status_type status
);
   import sne_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] fi_ff, fi_in;
   logic [2:0] fj_ff, fj_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;

   // hold state and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fi_ff    <= '0;
         fj_ff    <= '0;
         cnt_ff   <= '0;
         sel_ff   <= SEL_CENTER;
      end else begin
         state_ff <= state_in;
         fi_ff    <= fi_in;
         fj_ff    <= fj_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      fi_in         = fi_ff;
      fj_in         = fj_ff;
      cnt_in        = cnt_ff;
      sel_in        = sel_ff;
      req_stall     = 1'b1;
      cmd           = '0;
      cmd.fetch_row = fi_ff;
      cmd.fetch_col = fj_ff;
      cmd.grad_sel  = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.push = (req_operation == OP_PIXEL);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            fi_in = '0;
            fj_in = '0;
            state_in = status.emit_ready ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            cmd.fetch_issue = 1'b1;
            if (fj_ff == 3'(WIN - 1)) begin
               fj_in = '0;
               if (fi_ff == 3'(WIN - 1)) begin
                  cnt_in   = '0;
                  state_in = ST_FLUSH;
               end else begin
                  fi_in = fi_ff + 3'd1;
               end
            end else begin
               fj_in = fj_ff + 3'd1;
            end
         end
         ST_FLUSH: begin
            if (cnt_ff == 4'(FETCH_LAT - 1)) begin
               sel_in   = SEL_CENTER;
               state_in = ST_GRAD;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_GRAD: begin
            cmd.grad_load = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (sel_ff == SEL_SECOND) begin
               state_in = ST_ROOT_INIT;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_GRAD;
            end
         end
         ST_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == 4'(ROOT_STEPS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/sne_datapath.sv */
// Datapath of the Sobel edge thinning block: pixel history memory, position
// counters, window fetch, shared gradient unit, square root and result register.
// Depends on sne_pkg.
module sne_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sne_pkg::dp_cmd_type                  cmd,
   output sne_pkg::dp_status_type               status,
   input  logic [sne_pkg::PIXEL_W-1:0]          req_pixel,
   input  logic                                 csr_write_enable,
   input  logic [sne_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sne_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [sne_pkg::STRENGTH_W-1:0]       rsp_strength,
   output logic [sne_pkg::DIR_W-1:0]            rsp_direction,
   output logic                                 rsp_end_of_frame
);
   import sne_pkg::*;

   localparam int HIST_DEPTH = 4 * MAX_WIDTH + 8;
   localparam int AW = $clog2(HIST_DEPTH);
   localparam int PW = $clog2(HIST_DEPTH + 1);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int YW = HEIGHT_REG_W;
   localparam int RS = YW + 2;
   localparam int CS = WW + 3;
   localparam int DW = AW + 2;
   localparam logic [AW-1:0]        LAST_SLOT = AW'(HIST_DEPTH - 1);
   localparam logic signed [DW-1:0] DEPTH_S   = DW'(HIST_DEPTH);
   localparam logic signed [RS-1:0] R_TWO     = RS'(2);
   localparam logic signed [CS-1:0] C_TWO     = CS'(2);

   // configuration
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [WW-1:0]           w_eff;
   logic [YW-1:0]           h_eff;

   // positions and pointers
   logic [XW-1:0] in_col_ff;
   logic [YW-1:0] in_row_ff;
   logic [IW-1:0] in_index_ff;
   logic [PW-1:0] pend_ff;
   logic [AW-1:0] head_ff;
   logic [AW-1:0] slot_ff;
   logic [YW-1:0] out_y_ff;
   logic [XW-1:0] out_x_ff;
   logic          in_col_last, in_row_last, out_x_last, out_y_last;

   // history memory and fetch pipe
   logic [PIXEL_W-1:0]     hist_mem [HIST_DEPTH];
   logic [PIXEL_W-1:0]     rd_data_ff;
   logic signed [RS-1:0]   row_abs, row_d;
   logic signed [CS-1:0]   col_abs, col_d;
   logic signed [2:0]      dr_ff, dc_ff;
   logic signed [DW-1:0]   row_off, delta_ff, slot_sum;
   logic [AW-1:0]          addr_ff;
   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic [PIXEL_W-1:0]     win_ff [WIN*WIN];

   // gradient unit
   grad_type                 grads [9];
   grad_type                 pick;
   logic                     pick_ok;
   logic signed [GRAD_W-1:0] dx_ff, dy_ff;
   logic                     grad_ok_ff, sq_ok_ff;
   logic signed [2*GRAD_W-1:0] prod_x, prod_y;
   logic [SQUARE_W-1:0]      sqx_ff, sqy_ff;
   logic [MAG_W-1:0]         mag_sum;
   logic [MAG_W-1:0]         mag_ff, n1_ff, n2_ff;
   logic [DIR_W-1:0]         cls_ff, cls_now;
   logic [GRAD_W-1:0]        ax, ay;

   // square root
   logic [MAG_W-1:0] rv_ff, rres_ff, rbit_ff;
   logic [MAG_W:0]   trial;

   // result register
   logic                  out_valid_ff;
   logic [STRENGTH_W-1:0] out_strength_ff;
   logic [DIR_W-1:0]      out_dir_ff;
   logic                  out_eof_ff;

   // readiness
   logic [YW:0]  ry, y2, hm1;
   logic [WW:0]  rx, x2, wm1;

   // clamp the frame size
   always_comb begin
      if (width_ff < WIDTH_REG_W'(MIN_SIZE)) begin
         w_eff = WW'(MIN_SIZE);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      h_eff = (height_ff < HEIGHT_REG_W'(MIN_SIZE)) ? YW'(MIN_SIZE) : height_ff;
   end

   assign in_col_last = (WW'(in_col_ff) == w_eff - WW'(1));
   assign in_row_last = (in_row_ff == h_eff - YW'(1));
   assign out_x_last  = (WW'(out_x_ff) == w_eff - WW'(1));
   assign out_y_last  = (out_y_ff == h_eff - YW'(1));

   // registers, input and output positions
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_REG_W'(RESET_WIDTH);
         height_ff   <= HEIGHT_REG_W'(RESET_HEIGHT);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_index_ff <= '0;
         pend_ff     <= '0;
         head_ff     <= '0;
         slot_ff     <= '0;
         out_y_ff    <= '0;
         out_x_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_data[HEIGHT_REG_W-1:0];
            default: ;
         endcase
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_index_ff <= '0;
         pend_ff     <= '0;
         slot_ff     <= head_ff;
         out_y_ff    <= '0;
         out_x_ff    <= '0;
      end else begin
         // advance the input position on a pixel
         if (cmd.push) begin
            head_ff <= (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
            pend_ff <= pend_ff + PW'(1);
            if (in_col_last) begin
               in_col_ff <= '0;
               if (in_row_last) begin
                  in_row_ff   <= '0;
                  in_index_ff <= '0;
               end else begin
                  in_row_ff   <= in_row_ff + YW'(1);
                  in_index_ff <= in_index_ff + IW'(1);
               end
            end else begin
               in_col_ff   <= in_col_ff + XW'(1);
               in_index_ff <= in_index_ff + IW'(1);
            end
         end
         // advance the output position on a result
         if (cmd.finish) begin
            pend_ff <= pend_ff - PW'(1);
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + AW'(1);
            if (out_x_last) begin
               out_x_ff <= '0;
               out_y_ff <= out_y_last ? '0 : out_y_ff + YW'(1);
            end else begin
               out_x_ff <= out_x_ff + XW'(1);
            end
         end
      end
   end

   // pixel history: write on push, registered read for the fetch pipe
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         hist_mem[head_ff] <= req_pixel;
      end
      rd_data_ff <= hist_mem[addr_ff];
   end

   // fetch stage one: reflect the window position at the frame border
   always_comb begin
      row_abs = $signed(RS'(out_y_ff)) + $signed(RS'(cmd.fetch_row)) - R_TWO;
      if (row_abs < 0) begin
         row_d = -row_abs - $signed(RS'(out_y_ff));
      end else if (row_abs >= $signed(RS'(h_eff))) begin
         row_d = ($signed(RS'(h_eff)) <<< 1) - R_TWO - row_abs - $signed(RS'(out_y_ff));
      end else begin
         row_d = row_abs - $signed(RS'(out_y_ff));
      end
      col_abs = $signed(CS'(out_x_ff)) + $signed(CS'(cmd.fetch_col)) - C_TWO;
      if (col_abs < 0) begin
         col_d = -col_abs - $signed(CS'(out_x_ff));
      end else if (col_abs >= $signed(CS'(w_eff))) begin
         col_d = ($signed(CS'(w_eff)) <<< 1) - C_TWO - col_abs - $signed(CS'(out_x_ff));
      end else begin
         col_d = col_abs - $signed(CS'(out_x_ff));
      end
   end

   // fetch stage two: row offset in the history
   always_comb begin
      case (dr_ff)
         -3'sd2:  row_off = -($signed(DW'(w_eff)) <<< 1);
         -3'sd1:  row_off = -$signed(DW'(w_eff));
         3'sd1:   row_off = $signed(DW'(w_eff));
         3'sd2:   row_off = $signed(DW'(w_eff)) <<< 1;
         default: row_off = '0;
      endcase
      slot_sum = $signed({2'b00, slot_ff}) + delta_ff;
   end

   // fetch pipe registers and window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.fetch_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      dr_ff    <= row_d[2:0];
      dc_ff    <= col_d[2:0];
      delta_ff <= row_off + DW'(dc_ff);
      if (slot_sum < 0) begin
         addr_ff <= AW'(slot_sum + DEPTH_S);
      end else if (slot_sum >= DEPTH_S) begin
         addr_ff <= AW'(slot_sum - DEPTH_S);
      end else begin
         addr_ff <= AW'(slot_sum);
      end
      if (v4_ff) begin
         for (int i = 0; i < WIN * WIN - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WIN*WIN-1] <= rd_data_ff;
      end
   end

   // gradients at the nine centers of the window
   for (genvar ci = 0; ci < 3; ci++) begin : g_row
      for (genvar cj = 0; cj < 3; cj++) begin : g_col
         patch_type patch;
         always_comb begin
            for (int a = 0; a < 3; a++) begin
               for (int b = 0; b < 3; b++) begin
                  patch[a*3+b] = win_ff[(ci+a)*WIN + cj + b];
               end
            end
         end
         assign grads[ci*3+cj] = sobel(patch);
      end
   end

   // pick the gradient for the center or a neighbour along the axis
   always_comb begin
      pick    = grads[4];
      pick_ok = 1'b1;
      if (cmd.grad_sel == SEL_FIRST) begin
         case (cls_ff)
            DIR_VERTICAL: begin
               pick = grads[1]; pick_ok = (out_y_ff != '0);
            end
            DIR_ANTI_DIAG: begin
               pick = grads[2]; pick_ok = (out_y_ff != '0) && !out_x_last;
            end
            DIR_HORIZONTAL: begin
               pick = grads[3]; pick_ok = (out_x_ff != '0);
            end
            default: begin
               pick = grads[0]; pick_ok = (out_y_ff != '0) && (out_x_ff != '0);
            end
         endcase
      end else if (cmd.grad_sel == SEL_SECOND) begin
         case (cls_ff)
            DIR_VERTICAL: begin
               pick = grads[7]; pick_ok = !out_y_last;
            end
            DIR_ANTI_DIAG: begin
               pick = grads[6]; pick_ok = !out_y_last && (out_x_ff != '0);
            end
            DIR_HORIZONTAL: begin
               pick = grads[5]; pick_ok = !out_x_last;
            end
            default: begin
               pick = grads[8]; pick_ok = !out_y_last && !out_x_last;
            end
         endcase
      end
   end

   // axis class of the center gradient
   always_comb begin
      ax = dx_ff[GRAD_W-1] ? GRAD_W'(-dx_ff) : GRAD_W'(dx_ff);
      ay = dy_ff[GRAD_W-1] ? GRAD_W'(-dy_ff) : GRAD_W'(dy_ff);
      if (dx_ff == '0) begin
         cls_now = DIR_HORIZONTAL;
      end else if ((dy_ff != '0) && (dx_ff[GRAD_W-1] != dy_ff[GRAD_W-1])) begin
         cls_now = (ay > ax) ? DIR_VERTICAL : DIR_ANTI_DIAG;
      end else begin
         cls_now = (ay >= ax) ? DIR_DIAGONAL : DIR_HORIZONTAL;
      end
   end

   assign prod_x  = dx_ff * dx_ff;
   assign prod_y  = dy_ff * dy_ff;
   assign mag_sum = sq_ok_ff ? (MAG_W'(sqx_ff) + MAG_W'(sqy_ff)) : '0;
   assign trial   = {1'b0, rres_ff} + {1'b0, rbit_ff};

   // gradient, square, sum and root steps
   always_ff @(posedge clock) begin
      if (cmd.grad_load) begin
         dx_ff      <= pick.dx;
         dy_ff      <= pick.dy;
         grad_ok_ff <= pick_ok;
      end
      if (cmd.square) begin
         sqx_ff   <= prod_x[SQUARE_W-1:0];
         sqy_ff   <= prod_y[SQUARE_W-1:0];
         sq_ok_ff <= grad_ok_ff;
      end
      if (cmd.sum) begin
         case (cmd.grad_sel)
            SEL_CENTER: begin
               mag_ff <= mag_sum;
               cls_ff <= cls_now;
            end
            SEL_FIRST: n1_ff <= mag_sum;
            default:   n2_ff <= mag_sum;
         endcase
      end
      if (cmd.root_init) begin
         rv_ff   <= mag_ff;
         rres_ff <= '0;
         rbit_ff <= ROOT_FIRST_BIT;
      end else if (cmd.root_step) begin
         if ({1'b0, rv_ff} >= trial) begin
            rv_ff   <= rv_ff - trial[MAG_W-1:0];
            rres_ff <= (rres_ff >> 1) + rbit_ff;
         end else begin
            rres_ff <= rres_ff >> 1;
         end
         rbit_ff <= rbit_ff >> 2;
      end
   end

   // result register: load on finish, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         out_strength_ff <= ((mag_ff <= n1_ff) || (mag_ff <= n2_ff)) ?
                            '0 : rres_ff[STRENGTH_W-1:0];
         out_dir_ff      <= cls_ff;
         out_eof_ff      <= out_y_last && out_x_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_strength     = out_strength_ff;
   assign rsp_direction    = out_dir_ff;
   assign rsp_end_of_frame = out_eof_ff;

   // a result is due once its last needed pixel is in
   always_comb begin
      y2  = (YW+1)'(out_y_ff) + (YW+1)'(2);
      hm1 = (YW+1)'(h_eff) - (YW+1)'(1);
      ry  = (y2 < hm1) ? y2 : hm1;
      x2  = (WW+1)'(out_x_ff) + (WW+1)'(2);
      wm1 = (WW+1)'(w_eff) - (WW+1)'(1);
      rx  = (x2 < wm1) ? x2 : wm1;
      status.emit_ready = (pend_ff != '0) &&
                          ((IW'(pend_ff) > in_index_ff) ||
                           (ry < (YW+1)'(in_row_ff)) ||
                           ((ry == (YW+1)'(in_row_ff)) && (rx < (WW+1)'(in_col_ff))));
      status.out_busy   = out_valid_ff && rsp_stall;
   end

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(cmd.finish))
      else $error("result valid rose without a finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(out_valid_ff && rsp_stall))
      else $error("finish while the held result is stalled");

   a_cols_in_frame: assert property (@(posedge clock) disable iff (reset)
      (WW'(in_col_ff) < w_eff) && (WW'(out_x_ff) < w_eff))
      else $error("column counter past the row end");

   a_fetch_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch_issue |-> (pend_ff != '0))
      else $error("window fetch with no pending item");

endmodule

/* design/sobel_nms_edge_thinning.sv */
// Top level of the Sobel gradient and non-maximum suppression edge thinner.
// Instantiates sne_ctrl and sne_datapath; depends on sne_pkg.
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    req_operation, req_pixel
//   rsp       out        rsp_valid/stall    rsp_strength, rsp_direction, rsp_end_of_frame
//   csr       in         csr_write_enable   csr_index, csr_data
//
// An item that produces a result goes through accept, ready check, 25 history
// reads through the single memory read port, the fetch pipe flush, three passes
// of the shared gradient and square unit, and 11 steps of the square root.
// An item that produces no result goes through the accept and ready check only.
// Reset is synchronous; it sets the frame to 640 by 480 and empties the positions.
// A finished result sits in the output register while the next item is taken;
// the block holds before loading a new result only while that register is stalled.
module sobel_nms_edge_thinning #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [sne_pkg::PIXEL_W-1:0]          req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sne_pkg::STRENGTH_W-1:0]       rsp_strength,
   output logic [sne_pkg::DIR_W-1:0]            rsp_direction,
   output logic                                 rsp_end_of_frame,
   input  logic                                 csr_write_enable,
   input  logic [sne_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sne_pkg::CSR_DATA_W-1:0]       csr_data
);
   import sne_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sne_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .status        (status)
   );

   sne_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pixel        (req_pixel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_strength     (rsp_strength),
      .rsp_direction    (rsp_direction),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the Sobel gradient and edge thinning block.
// Depends on sne_pkg and sobel_nms_edge_thinning; a built-in predictor or typed expectations check every result.
module testbench;
   import sne_pkg::*;

   localparam int HIST_DEPTH   = 4 * 1024 + 8;
   localparam int SETTLE       = 80;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int HOLDOFF_LEN  = 400;

   typedef struct {
      logic [STRENGTH_W-1:0] strength;
      logic [DIR_W-1:0]      direction;
      logic                  eof;
   } edge_result_type;

   typedef struct {
      logic                  op;
      logic [PIXEL_W-1:0]    pix;
      bit                    typed;
      bit                    has_result;
      edge_result_type       res;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_operation = OP_PIXEL;
   logic [PIXEL_W-1:0]      req_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STRENGTH_W-1:0]   rsp_strength;
   logic [DIR_W-1:0]        rsp_direction;
   logic                    rsp_end_of_frame;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   sobel_nms_edge_thinning DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [PIXEL_W-1:0] pixel_history [HIST_DEPTH];
   int   hist_head, in_col, in_row, out_pos, pending;
   int   width_reg, height_reg;
   int   cw, ch, cy, cx, cpend;
   edge_result_type expected_results [$];
   bit   failed = 1'b0;
   bit   holdoff = 1'b0;
   int   stall_mode = 0;
   int   cycles = 0;
   event start_holdoff;

   function automatic int mirror(int i, int n);
      if (i < 0) return -i;
      if (i >= n) return 2 * n - 2 - i;
      return i;
   endfunction

   function automatic int hist_pixel(int r, int c);
      longint delta, idx;
      delta = longint'(mirror(r, ch) - cy) * cw + (mirror(c, cw) - cx);
      idx = (longint'(hist_head) - (longint'(cpend) - delta)) % HIST_DEPTH;
      if (idx < 0) idx += HIST_DEPTH;
      return int'(pixel_history[idx]);
   endfunction

   function automatic void sobel_at(int r, int c, output int gx, output int gy);
      gx = (hist_pixel(r-1, c+1) - hist_pixel(r-1, c-1))
         + 2 * (hist_pixel(r, c+1) - hist_pixel(r, c-1))
         + (hist_pixel(r+1, c+1) - hist_pixel(r+1, c-1));
      gy = (hist_pixel(r+1, c-1) - hist_pixel(r-1, c-1))
         + 2 * (hist_pixel(r+1, c) - hist_pixel(r-1, c))
         + (hist_pixel(r+1, c+1) - hist_pixel(r-1, c+1));
   endfunction

   function automatic int energy_at(int r, int c);
      int gx, gy;
      if (r < 0 || r >= ch || c < 0 || c >= cw) return 0;
      sobel_at(r, c, gx, gy);
      return gx * gx + gy * gy;
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // advance the predictor by one accepted item; return 1 if a result is due
   function automatic bit predict_edge(logic op, logic [PIXEL_W-1:0] pix,
                                       output edge_result_type res);
      int w, h, total, in_idx, y, x, gx, gy, ax, ay, axis, m, n1, n2, root, ry, rx;
      bit ready;
      w = clamp(width_reg, MIN_SIZE, 1024);
      h = clamp(height_reg, MIN_SIZE, MAX_HEIGHT);
      total = w * h;
      if (op == OP_PIXEL) begin
         pixel_history[hist_head] = pix;
         hist_head = (hist_head + 1) % HIST_DEPTH;
         pending++;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
      end
      if (pending == 0) return 0;
      if (out_pos >= total) out_pos = 0;
      y = out_pos / w;
      x = out_pos % w;
      in_idx = in_row * w + in_col;
      if (pending > in_idx) begin
         ready = 1;
      end else begin
         ry = (y + 2 < h - 1) ? y + 2 : h - 1;
         rx = (x + 2 < w - 1) ? x + 2 : w - 1;
         ready = (ry * w + rx) < in_idx;
      end
      if (!ready) return 0;
      cw = w; ch = h; cy = y; cx = x; cpend = pending;
      sobel_at(y, x, gx, gy);
      m = gx * gx + gy * gy;
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      if (gx == 0) axis = DIR_HORIZONTAL;
      else if (gy != 0 && ((gx < 0) != (gy < 0))) axis = (ay > ax) ? DIR_VERTICAL : DIR_ANTI_DIAG;
      else axis = (ay >= ax) ? DIR_DIAGONAL : DIR_HORIZONTAL;
      case (axis)
         DIR_VERTICAL: begin
            n1 = energy_at(y-1, x); n2 = energy_at(y+1, x);
         end
         DIR_ANTI_DIAG: begin
            n1 = energy_at(y-1, x+1); n2 = energy_at(y+1, x-1);
         end
         DIR_HORIZONTAL: begin
            n1 = energy_at(y, x-1); n2 = energy_at(y, x+1);
         end
         default: begin
            n1 = energy_at(y-1, x-1); n2 = energy_at(y+1, x+1);
         end
      endcase
      root = 0;
      if (m > n1 && m > n2) begin
         while ((root + 1) * (root + 1) <= m) root++;
      end
      res.strength = STRENGTH_W'(root);
      res.direction = DIR_W'(axis);
      res.eof = (out_pos == total - 1);
      out_pos++;
      if (out_pos >= total) out_pos = 0;
      pending--;
      return 1;
   endfunction

   // offer one item and hold it until accepted
   task automatic send_item(logic op, logic [PIXEL_W-1:0] pix,
                            bit typed = 0, bit has_result = 0,
                            edge_result_type typed_res = '{default: '0});
      edge_result_type res;
      bit due;
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_pixel <= pix;
      do @(posedge clock); while (req_stall);
      due = predict_edge(op, pix, res);
      if (typed) begin
         if (has_result) expected_results.push_back(typed_res);
      end else if (due) begin
         expected_results.push_back(res);
      end
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // drop valid, let the block finish, then write a register
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int val);
      pause_sender(0);
      wait (expected_results.size() == 0);
      repeat (SETTLE) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_reg = val & 'h7FF;
      else height_reg = val & 'hFFF;
      in_col = 0; in_row = 0; out_pos = 0; pending = 0;
   endtask

   // receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (holdoff) rsp_stall <= 1'b1;
      else case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         default: rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
   end

   initial begin
      forever begin
         @(start_holdoff);
         holdoff = 1'b1;
         repeat (HOLDOFF_LEN) @(posedge clock);
         holdoff = 1'b0;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      edge_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: strength %0d direction %0d", rsp_strength, rsp_direction);
            failed = 1'b1;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_strength !== exp_res.strength) begin
               $error("strength: expected %0d, got %0d", exp_res.strength, rsp_strength);
               failed = 1'b1;
            end
            if (rsp_direction !== exp_res.direction) begin
               $error("direction: expected %0d, got %0d", exp_res.direction, rsp_direction);
               failed = 1'b1;
            end
            if (rsp_end_of_frame !== exp_res.eof) begin
               $error("end_of_frame: expected %0d, got %0d", exp_res.eof, rsp_end_of_frame);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // send one frame of random content, shaped so that edges appear
   task automatic send_frame(int w, int h, bit drain_after);
      int style, k;
      logic [PIXEL_W-1:0] p;
      style = $urandom_range(0, 3);
      for (k = 0; k < w * h; k++) begin
         case (style)
            0: p = PIXEL_W'($urandom_range(0, 255));
            1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: p = ((k % w) < w / 2) ? 8'h00 : 8'hFF;
            default: p = ((k / w + k % w) % 3 == 0) ? 8'hFF : PIXEL_W'($urandom_range(0, 40));
         endcase
         if ($urandom_range(0, 19) == 0) send_item(OP_DRAIN, PIXEL_W'($urandom_range(0, 255)));
         send_item(OP_PIXEL, p);
         if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 8));
      end
      if (drain_after) begin
         for (k = 0; k < 2 * w + 4; k++) send_item(OP_DRAIN, PIXEL_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      stim_row_type rows [$];
      edge_result_type flat;
      int count, w, h, k;
      bit holdoff_sent;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      hist_head = 0; in_col = 0; in_row = 0; out_pos = 0; pending = 0;
      holdoff_sent = 1'b0;
      foreach (pixel_history[i]) pixel_history[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: 640 by 480, items with nothing ready give nothing
      rows.push_back('{OP_DRAIN, 8'h00, 1, 0, '{0, 0, 0}});
      rows.push_back('{OP_PIXEL, 8'h00, 1, 0, '{0, 0, 0}});
      rows.push_back('{OP_PIXEL, 8'hFF, 1, 0, '{0, 0, 0}});
      rows.push_back('{OP_DRAIN, 8'hFF, 1, 0, '{0, 0, 0}});
      foreach (rows[i]) send_item(rows[i].op, rows[i].pix, rows[i].typed,
                                  rows[i].has_result, rows[i].res);
      rows.delete();

      // smallest frame, flat: all strengths zero on the horizontal axis
      write_reg(REG_IMAGE_WIDTH, 0);
      write_reg(REG_IMAGE_HEIGHT, 0);
      flat = '{0, DIR_HORIZONTAL, 0};
      for (k = 0; k < 8; k++) rows.push_back('{OP_PIXEL, 8'h80, 1, 0, flat});
      rows.push_back('{OP_PIXEL, 8'h80, 1, 1, flat});
      for (k = 0; k < 7; k++) rows.push_back('{OP_DRAIN, 8'h00, 1, 1, flat});
      flat.eof = 1'b1;
      rows.push_back('{OP_DRAIN, 8'h00, 1, 1, flat});
      flat.eof = 1'b0;
      rows.push_back('{OP_DRAIN, 8'h00, 1, 0, flat});
      // full-scale step content, checked by the predictor
      for (k = 0; k < 9; k++)
         rows.push_back('{OP_PIXEL, (k % 3 == 2) ? 8'hFF : 8'h00, 0, 0, flat});
      foreach (rows[i]) send_item(rows[i].op, rows[i].pix, rows[i].typed,
                                  rows[i].has_result, rows[i].res);
      // next frame pushes the previous one out
      for (k = 0; k < 9; k++) send_item(OP_PIXEL, (k % 2) ? 8'hFF : 8'h00);
      for (k = 0; k < 12; k++) send_item(OP_DRAIN, 8'h00);

      // largest sizes: width saturates to the maximum, no result gets ready
      write_reg(REG_IMAGE_WIDTH, 2047);
      write_reg(REG_IMAGE_HEIGHT, 4095);
      for (k = 0; k < 20; k++)
         send_item(k % 4 == 3 ? OP_DRAIN : OP_PIXEL, PIXEL_W'($urandom_range(0, 255)));
      // tallest frame at the smallest width: a few rows come out
      write_reg(REG_IMAGE_WIDTH, 3);
      for (k = 0; k < 24; k++) send_item(OP_PIXEL, $urandom_range(0, 1) ? 8'hFF : 8'h00);
      // pending results dropped by the next write

      // random frames of small sizes
      count = 0;
      while (count < 700) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(3, 8);
         h = $urandom_range(3, 6);
         write_reg(REG_IMAGE_WIDTH, w);
         write_reg(REG_IMAGE_HEIGHT, h);
         stall_mode = $urandom_range(0, 2);
         // hold off the receiver once, early in the random part
         if (count > 200 && !holdoff_sent) begin
            holdoff_sent = 1'b1;
            -> start_holdoff;
         end
         for (k = $urandom_range(1, 3); k > 0; k--) begin
            send_frame(w, h, $urandom_range(0, 2) != 0);
            count += w * h;
         end
         for (k = 0; k < 2 * w + 4; k++) send_item(OP_DRAIN, PIXEL_W'($urandom_range(0, 255)));
         count += 2 * w + 4;
         if ($urandom_range(0, 3) == 0) begin
            // broken frame, left for the next write to drop
            for (k = $urandom_range(1, w * h); k > 0; k--)
               send_item(OP_PIXEL, PIXEL_W'($urandom_range(0, 255)));
         end
      end

      pause_sender(0);
      wait (expected_results.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
